// ===== rtl/core/sstv_vis_header_detector_unit_defines.svh =====
// Assertion macros used by the checker file of the header detector.
`ifndef SSTV_VIS_HEADER_DETECTOR_UNIT_DEFINES_SVH
`define SSTV_VIS_HEADER_DETECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SVHD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SVHD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/svhd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package svhd_pkg;

  localparam int unsigned TONE_W       = 12;
  localparam int unsigned WINDOW_SLOTS = 45;
  localparam int unsigned IDX_W        = $clog2(WINDOW_SLOTS + 1);
  localparam int unsigned PC_W         = 4;
  localparam int unsigned BITS_N       = 8;
  localparam int unsigned CODE_W       = 7;
  localparam int unsigned SHIFT_W      = 13;
  localparam int unsigned DIFF_W       = TONE_W + 2;
  localparam int unsigned DROP_SLOTS   = 3;

  localparam logic [1:0] STATUS_NONE    = 2'd0;
  localparam logic [1:0] STATUS_BAD_BIT = 2'd1;
  localparam logic [1:0] STATUS_PARITY  = 2'd2;
  localparam logic [1:0] STATUS_VALID   = 2'd3;

  localparam logic signed [DIFF_W-1:0] LEAD_LO = -14'sd25;
  localparam logic signed [DIFF_W-1:0] LEAD_HI = 14'sd25;
  localparam logic signed [DIFF_W-1:0] SYNC_LO = -14'sd725;
  localparam logic signed [DIFF_W-1:0] SYNC_HI = -14'sd675;
  localparam logic signed [DIFF_W-1:0] ZERO_LO = -14'sd625;
  localparam logic signed [DIFF_W-1:0] ZERO_HI = -14'sd575;
  localparam logic signed [DIFF_W-1:0] ONE_LO  = -14'sd825;
  localparam logic signed [DIFF_W-1:0] ONE_HI  = -14'sd775;
  localparam logic signed [SHIFT_W-1:0] CENTER_HZ = 13'sd1900;

  typedef enum logic [1:0] {
    OP_REF  = 2'd0,
    OP_LEAD = 2'd1,
    OP_SYNC = 2'd2,
    OP_BIT  = 2'd3
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] offset;
    logic             last;
  } cw_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ADDR = 4'b0010,
    ST_EVAL = 4'b0100,
    ST_POST = 4'b1000
  } state_t;

  // Program for one (phase, reference) attempt. The reference read is offset by
  // the reference slot, every other read by the bit phase.
  function automatic cw_t program_rom(input logic [PC_W-1:0] pc);
    cw_t cw;
    cw = '{op: OP_BIT, offset: '0, last: 1'b0};
    unique case (pc)
      4'd0:    cw = '{op: OP_REF,  offset: IDX_W'(0),  last: 1'b0};
      4'd1:    cw = '{op: OP_LEAD, offset: IDX_W'(3),  last: 1'b0};
      4'd2:    cw = '{op: OP_LEAD, offset: IDX_W'(6),  last: 1'b0};
      4'd3:    cw = '{op: OP_LEAD, offset: IDX_W'(9),  last: 1'b0};
      4'd4:    cw = '{op: OP_LEAD, offset: IDX_W'(12), last: 1'b0};
      4'd5:    cw = '{op: OP_SYNC, offset: IDX_W'(15), last: 1'b0};
      4'd6:    cw = '{op: OP_SYNC, offset: IDX_W'(WINDOW_SLOTS - 3), last: 1'b0};
      4'd7:    cw = '{op: OP_BIT,  offset: IDX_W'(18), last: 1'b0};
      4'd8:    cw = '{op: OP_BIT,  offset: IDX_W'(21), last: 1'b0};
      4'd9:    cw = '{op: OP_BIT,  offset: IDX_W'(24), last: 1'b0};
      4'd10:   cw = '{op: OP_BIT,  offset: IDX_W'(27), last: 1'b0};
      4'd11:   cw = '{op: OP_BIT,  offset: IDX_W'(30), last: 1'b0};
      4'd12:   cw = '{op: OP_BIT,  offset: IDX_W'(33), last: 1'b0};
      4'd13:   cw = '{op: OP_BIT,  offset: IDX_W'(36), last: 1'b0};
      4'd14:   cw = '{op: OP_BIT,  offset: IDX_W'(39), last: 1'b1};
      default: cw = '{op: OP_BIT,  offset: IDX_W'(39), last: 1'b1};
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/svhd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module svhd_ram #(
  parameter int unsigned WIDTH = svhd_pkg::TONE_W,
  parameter int unsigned DEPTH = svhd_pkg::WINDOW_SLOTS,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/sstv_vis_header_detector_unit.sv =====
// SSTV VIS header detector.
// Input channel: one 12-bit tone estimate per word (in_valid, in_stall, tone_hz).
// Output channel: one result word (out_valid, out_stall, status, vis_code,
// freq_shift) for every input word that fills the 45-slot window.
// A word that does not fill the window is stored and gives no result.
// The word that fills it starts a search of three bit phases by three reference
// slots; each program step passes through ST_ADDR and then ST_EVAL, because of the
// registered read port of the window memory. ST_POST then moves the result
// into the output register. in_stall is high during the search and the move.
// A result waits in the output register while out_stall is high; new words are
// still taken meanwhile, but a finished search waits until that register is free.
// After a valid code the window is emptied; after any other result the three
// oldest slots are dropped.
// Reset empties the window and the output register; in_stall is high during reset.
`timescale 1ns / 1ps
`default_nettype none

module sstv_vis_header_detector_unit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [11:0]         tone_hz,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [1:0]               status,
  output logic [6:0]               vis_code,
  output logic signed [12:0]       freq_shift
);

  localparam int unsigned IW = svhd_pkg::IDX_W;
  localparam int unsigned AW = $clog2(svhd_pkg::WINDOW_SLOTS);
  localparam logic [IW:0] SLOTS_X = (IW + 1)'(svhd_pkg::WINDOW_SLOTS);

  svhd_pkg::state_t state;
  logic [svhd_pkg::PC_W-1:0]   pc;
  logic [1:0]                  ph_p;
  logic [1:0]                  ph_r;
  logic [IW-1:0]               base;
  logic [IW-1:0]               count;
  logic [svhd_pkg::TONE_W-1:0] ref_tone;
  logic [svhd_pkg::BITS_N-1:0] bits;
  logic [1:0]                  res_status;
  logic [svhd_pkg::CODE_W-1:0] res_code;
  logic signed [svhd_pkg::SHIFT_W-1:0] res_shift;

  svhd_pkg::cw_t               cw;
  logic [IW-1:0]               logical;
  logic [IW:0]                 rsum;
  logic [IW:0]                 wsum;
  logic [IW:0]                 bsum;
  logic [IW-1:0]               raddr_full;
  logic [IW-1:0]               waddr_full;
  logic [IW-1:0]               base_next;
  logic [svhd_pkg::TONE_W-1:0] rdata;
  logic signed [svhd_pkg::DIFF_W-1:0] diff;
  logic                        in_lead;
  logic                        in_sync;
  logic                        in_zero;
  logic                        in_one;
  logic [svhd_pkg::BITS_N-1:0] bits_next;
  logic                        parity_ok;
  logic                        accept;
  logic                        out_free;

  assign cw      = svhd_pkg::program_rom(pc);
  assign logical = cw.offset + ((cw.op == svhd_pkg::OP_REF) ? IW'(ph_r) : IW'(ph_p));

  assign rsum       = {1'b0, base} + {1'b0, logical};
  assign raddr_full = (rsum >= SLOTS_X) ? IW'(rsum - SLOTS_X) : rsum[IW-1:0];
  assign wsum       = {1'b0, base} + {1'b0, count};
  assign waddr_full = (wsum >= SLOTS_X) ? IW'(wsum - SLOTS_X) : wsum[IW-1:0];
  assign bsum       = {1'b0, base} + (IW + 1)'(svhd_pkg::DROP_SLOTS);
  assign base_next  = (bsum >= SLOTS_X) ? IW'(bsum - SLOTS_X) : bsum[IW-1:0];

  assign diff = $signed({2'b00, rdata}) - $signed({2'b00, ref_tone});
  assign in_lead = (diff >= svhd_pkg::LEAD_LO) && (diff <= svhd_pkg::LEAD_HI);
  assign in_sync = (diff >= svhd_pkg::SYNC_LO) && (diff <= svhd_pkg::SYNC_HI);
  assign in_zero = (diff >= svhd_pkg::ZERO_LO) && (diff <= svhd_pkg::ZERO_HI);
  assign in_one  = (diff >= svhd_pkg::ONE_LO) && (diff <= svhd_pkg::ONE_HI);

  assign bits_next = {in_one, bits[svhd_pkg::BITS_N-1:1]};
  assign parity_ok = ((^bits_next[svhd_pkg::CODE_W-1:0]) == bits_next[svhd_pkg::BITS_N-1]);

  assign in_stall = rst || (state != svhd_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  svhd_ram #(
    .WIDTH(svhd_pkg::TONE_W),
    .DEPTH(svhd_pkg::WINDOW_SLOTS)
  ) u_window (
    .clk  (clk),
    .we   (accept),
    .waddr(waddr_full[AW-1:0]),
    .wdata(tone_hz),
    .raddr(raddr_full[AW-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= svhd_pkg::ST_IDLE;
      pc        <= '0;
      ph_p      <= '0;
      ph_r      <= '0;
      base      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == svhd_pkg::ST_POST && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        svhd_pkg::ST_IDLE: begin
          if (accept) begin
            if (count == IW'(svhd_pkg::WINDOW_SLOTS - 1)) begin
              pc    <= '0;
              ph_p  <= '0;
              ph_r  <= '0;
              state <= svhd_pkg::ST_ADDR;
            end else begin
              count <= count + IW'(1);
            end
          end
        end
        svhd_pkg::ST_ADDR: begin
          state <= svhd_pkg::ST_EVAL;
        end
        svhd_pkg::ST_EVAL: begin
          priority if (cw.op == svhd_pkg::OP_REF) begin
            ref_tone <= rdata;
            pc       <= pc + svhd_pkg::PC_W'(1);
            state    <= svhd_pkg::ST_ADDR;
          end else if ((cw.op == svhd_pkg::OP_LEAD && !in_lead) ||
                       (cw.op == svhd_pkg::OP_SYNC && !in_sync)) begin
            pc <= '0;
            if (ph_r == 2'd2) begin
              ph_r <= '0;
              if (ph_p == 2'd2) begin
                res_status <= svhd_pkg::STATUS_NONE;
                res_code   <= '0;
                res_shift  <= '0;
                state      <= svhd_pkg::ST_POST;
              end else begin
                ph_p  <= ph_p + 2'd1;
                state <= svhd_pkg::ST_ADDR;
              end
            end else begin
              ph_r  <= ph_r + 2'd1;
              state <= svhd_pkg::ST_ADDR;
            end
          end else if (cw.op == svhd_pkg::OP_LEAD || cw.op == svhd_pkg::OP_SYNC) begin
            pc    <= pc + svhd_pkg::PC_W'(1);
            state <= svhd_pkg::ST_ADDR;
          end else if (!in_zero && !in_one) begin
            res_status <= svhd_pkg::STATUS_BAD_BIT;
            res_code   <= '0;
            res_shift  <= '0;
            state      <= svhd_pkg::ST_POST;
          end else if (!cw.last) begin
            bits  <= bits_next;
            pc    <= pc + svhd_pkg::PC_W'(1);
            state <= svhd_pkg::ST_ADDR;
          end else begin
            res_code <= bits_next[svhd_pkg::CODE_W-1:0];
            if (parity_ok) begin
              res_status <= svhd_pkg::STATUS_VALID;
              res_shift  <= $signed({1'b0, ref_tone}) - svhd_pkg::CENTER_HZ;
            end else begin
              res_status <= svhd_pkg::STATUS_PARITY;
              res_shift  <= '0;
            end
            state <= svhd_pkg::ST_POST;
          end
        end
        svhd_pkg::ST_POST: begin
          if (out_free) begin
            status     <= res_status;
            vis_code   <= res_code;
            freq_shift <= res_shift;
            if (res_status == svhd_pkg::STATUS_VALID) begin
              count <= '0;
            end else begin
              base  <= base_next;
              count <= IW'(svhd_pkg::WINDOW_SLOTS - svhd_pkg::DROP_SLOTS);
            end
            state <= svhd_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= svhd_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/svhd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "sstv_vis_header_detector_unit_defines.svh"

module svhd_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic [11:0]        tone_hz,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [1:0]         status,
  input wire logic [6:0]         vis_code,
  input wire logic signed [12:0] freq_shift
);

  `SVHD_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid, "result word dropped while stalled")
  `SVHD_ASSERT_IMP(a_shift_only_valid, clk, rst, out_valid && status != svhd_pkg::STATUS_VALID, freq_shift == 13'sd0, "frequency offset without a valid code")
  `SVHD_ASSERT_IMP(a_code_zero, clk, rst, out_valid && (status == svhd_pkg::STATUS_NONE || status == svhd_pkg::STATUS_BAD_BIT), vis_code == 7'd0, "code given without decoded bits")
  `SVHD_ASSERT_IMP(a_result_after_search, clk, rst, $rose(out_valid), $past(in_stall), "result word without a preceding search")

endmodule

bind sstv_vis_header_detector_unit svhd_checker u_svhd_checker (.*);

`default_nettype wire
